@@ design/u2a_pkg.sv @@
// ----------------------------------------------------------------------------
// u2a_pkg - shared definitions for the utf-8 to ascii transliterator
// Byte class masks, code point width and the latin-1 letter folding table.
// ----------------------------------------------------------------------------
`default_nettype none

package u2a_pkg;

	localparam int BYTE_W  = 8;
	localparam int CHAR_W  = 7;
	localparam int CNT_W   = 12;
	localparam int LEAD_W  = 5;
	localparam int SKIP_W  = 2;
	localparam int CP_W    = 11;

	// byte class masks and patterns
	localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD2_PAT  = 8'hC0;
	localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
	localparam logic [BYTE_W-1:0] LEAD3_PAT  = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
	localparam logic [BYTE_W-1:0] LEAD4_PAT  = 8'hF0;

	// skip counts after multibyte leads
	localparam logic [SKIP_W-1:0] SKIP_LEAD3 = 2'd2;
	localparam logic [SKIP_W-1:0] SKIP_LEAD4 = 2'd3;

	// fixed characters
	localparam logic [CHAR_W-1:0] CH_QUESTION = 7'h3F;
	localparam logic [CHAR_W-1:0] CH_SPACE    = 7'h20;
	localparam logic [CHAR_W-1:0] CH_STAR     = 7'h2A;
	localparam logic [CHAR_W-1:0] CH_NUL      = 7'h00;

	localparam logic [CNT_W-1:0] LIMIT_RESET = 12'd255;

	// fold a two-byte code point to a plain ascii character
	function automatic logic [CHAR_W-1:0] map_code_point(input logic [CP_W-1:0] cp);
		logic [CHAR_W-1:0] ch;
		ch = CH_QUESTION;
		if (cp[CP_W-1:8] == 3'd0) begin
			unique case (cp[7:0])
				8'hB0:                       ch = CH_STAR;
				8'hC0, 8'hC2:                ch = 7'h41; // A
				8'hC7:                       ch = 7'h43; // C
				8'hC8, 8'hC9, 8'hCA:         ch = 7'h45; // E
				8'hCE:                       ch = 7'h49; // I
				8'hD4:                       ch = 7'h4F; // O
				8'hD9, 8'hDB:                ch = 7'h55; // U
				8'hE0, 8'hE2, 8'hE4:         ch = 7'h61; // a
				8'hE7:                       ch = 7'h63; // c
				8'hE8, 8'hE9, 8'hEA, 8'hEB:  ch = 7'h65; // e
				8'hEC, 8'hEE, 8'hEF:         ch = 7'h69; // i
				8'hF2, 8'hF4, 8'hF6:         ch = 7'h6F; // o
				8'hF9, 8'hFB, 8'hFC:         ch = 7'h75; // u
				default:                     ch = CH_QUESTION;
			endcase
		end
		return ch;
	endfunction

endpackage

`default_nettype wire

@@ design/utf8_to_ascii_transliterator.sv @@
// ----------------------------------------------------------------------------
// utf8_to_ascii_transliterator - utf-8 byte stream to ascii characters
// Decodes one byte per clock while not stalled, folds accented latin-1 letters, limits length.
// ----------------------------------------------------------------------------
// One byte enters per clock while the output is not stalled and runs through
// an input register, one pass of decode logic and a result register; a new
// byte can be taken every cycle unless a stalled result holds the pipeline.
// The per-string state (pending lead, skip count, emitted count) updates in
// the same pass. A zero byte always produces a terminator (tdata zero, tlast
// high) and clears the string state. Bytes that produce nothing (two-byte
// leads, skipped continuation bytes, stray bytes, bytes past the limit) are
// consumed silently. cfg_wr_data sets the per-string character limit and is
// meant to be written while the stream is idle.
`default_nettype none

module utf8_to_ascii_transliterator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [11:0] cfg_wr_data,   // output_limit
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] in_byte
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,  // [6:0] out_char, [7] zero fill
	output logic             m_axis_tlast   // is_last
);

	localparam int BW = u2a_pkg::BYTE_W;
	localparam int CW = u2a_pkg::CHAR_W;
	localparam int NW = u2a_pkg::CNT_W;

	logic [NW-1:0]             limit_q;
	logic                      valid_s1;
	logic [BW-1:0]             byte_s1;
	logic                      valid_s2;
	logic [CW-1:0]             char_s2;
	logic                      last_s2;

	logic [u2a_pkg::LEAD_W-1:0] lead_q;
	logic                       await_q;
	logic [u2a_pkg::SKIP_W-1:0] skip_q;
	logic [NW-1:0]              count_q;
	logic                       reached_q;

	logic advance;
	logic step;

	// next-state values from the decode pass
	logic [u2a_pkg::LEAD_W-1:0] lead_d;
	logic                       await_d;
	logic [u2a_pkg::SKIP_W-1:0] skip_d;
	logic [NW-1:0]              count_d;
	logic                       reached_d;
	logic                       emit_d;
	logic [CW-1:0]              char_d;
	logic                       last_d;

	// candidate character and whether it goes through the limit check
	logic                       want;
	logic [CW-1:0]              want_char;
	logic [NW-1:0]              count_inc;

	assign advance       = !valid_s2 || m_axis_tready;
	assign step          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {1'b0, char_s2};
	assign m_axis_tlast  = last_s2;

	// limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= u2a_pkg::LIMIT_RESET;
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	// byte classification and candidate character
	always_comb begin
		lead_d    = lead_q;
		await_d   = await_q;
		skip_d    = skip_q;
		want      = 1'b0;
		want_char = u2a_pkg::CH_QUESTION;
		last_d    = 1'b0;
		priority if (byte_s1 == '0) begin
			lead_d  = '0;
			await_d = 1'b0;
			skip_d  = '0;
			last_d  = 1'b1;
		end else if (reached_q) begin
			want = 1'b0;
		end else if (skip_q != '0) begin
			skip_d = skip_q - 1'b1;
		end else if (await_q) begin
			await_d   = 1'b0;
			lead_d    = '0;
			want      = 1'b1;
			want_char = u2a_pkg::map_code_point({lead_q, byte_s1[5:0]});
		end else if (!byte_s1[BW-1]) begin
			want      = 1'b1;
			want_char = byte_s1[CW-1:0];
		end else if ((byte_s1 & u2a_pkg::LEAD2_MASK) == u2a_pkg::LEAD2_PAT) begin
			lead_d  = byte_s1[u2a_pkg::LEAD_W-1:0];
			await_d = 1'b1;
		end else if ((byte_s1 & u2a_pkg::LEAD3_MASK) == u2a_pkg::LEAD3_PAT) begin
			skip_d    = u2a_pkg::SKIP_LEAD3;
			want      = 1'b1;
			want_char = u2a_pkg::CH_QUESTION;
		end else if ((byte_s1 & u2a_pkg::LEAD4_MASK) == u2a_pkg::LEAD4_PAT) begin
			skip_d    = u2a_pkg::SKIP_LEAD4;
			want      = 1'b1;
			want_char = u2a_pkg::CH_SPACE;
		end else begin
			want = 1'b0;
		end
	end

	// limit check and count update
	assign count_inc = count_q + 1'b1;

	always_comb begin
		count_d   = count_q;
		reached_d = reached_q;
		emit_d    = 1'b0;
		char_d    = want_char;
		if (last_d) begin
			count_d   = '0;
			reached_d = 1'b0;
			emit_d    = 1'b1;
			char_d    = u2a_pkg::CH_NUL;
		end else if (want) begin
			if (count_q >= limit_q) begin
				reached_d = 1'b1;
			end else begin
				emit_d    = 1'b1;
				count_d   = count_inc;
				reached_d = (count_inc >= limit_q);
			end
		end
	end

	// string state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q    <= '0;
			await_q   <= 1'b0;
			skip_q    <= '0;
			count_q   <= '0;
			reached_q <= 1'b0;
		end else if (step) begin
			lead_q    <= lead_d;
			await_q   <= await_d;
			skip_q    <= skip_d;
			count_q   <= count_d;
			reached_q <= reached_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1 && emit_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit_d) begin
			char_s2 <= char_d;
			last_s2 <= last_d;
		end
	end

	// terminator carries a zero character
	a_term_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && last_s2 |-> char_s2 == u2a_pkg::CH_NUL)
		else $error("terminator with nonzero character");

	// ordinary characters are never zero
	a_char_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !last_s2 |-> char_s2 != u2a_pkg::CH_NUL)
		else $error("zero character without terminator");

	// a terminator leaves the string state clear
	a_term_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && byte_s1 == '0 |=> count_q == '0 && !await_q && skip_q == '0 && !reached_q)
		else $error("string state not cleared after terminator");

	// a pending lead and a skip run never coexist
	a_await_skip: assert property (@(posedge clk) disable iff (!arst_n)
		!(await_q && skip_q != '0))
		else $error("pending lead while skipping");

	// a stalled result is not overwritten
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !m_axis_tready |=> valid_s2 && $stable(char_s2) && $stable(last_s2))
		else $error("result changed while stalled");

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top - testbench for the utf-8 to ascii transliterator
// Streams directed and random utf-8 bytes under several length limits and
// handshake pressures, and checks every output transaction against a
// cycle-free model of the decoder kept in a small scoreboard.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PIPE_LATENCY   = 2;
	localparam int SETTLE_CYCLES  = PIPE_LATENCY + 3;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RUN_BYTES      = 175;
	localparam int MAX_REPORTS    = 10;

	typedef struct packed {
		logic [u2a_pkg::CHAR_W-1:0] ch;
		logic                       last;
	} ascii_result_t;

	// expected ascii output, kept in step with accepted input bytes
	class translit_scoreboard;
		logic [u2a_pkg::CNT_W-1:0]  char_limit;
		logic [u2a_pkg::LEAD_W-1:0] lead_bits;
		bit                         want_second;
		logic [u2a_pkg::SKIP_W-1:0] skip_left;
		logic [u2a_pkg::CNT_W-1:0]  char_count;
		bit                         at_limit;
		ascii_result_t              expected_q[$];
		int                         mismatches;
		int                         bytes_seen;
		int                         chars_seen;
		int                         terms_seen;

		function new();
			char_limit  = u2a_pkg::LIMIT_RESET;
			mismatches  = 0;
			bytes_seen  = 0;
			chars_seen  = 0;
			terms_seen  = 0;
			clear_string();
		endfunction

		function void clear_string();
			lead_bits   = '0;
			want_second = 0;
			skip_left   = '0;
			char_count  = '0;
			at_limit    = 0;
		endfunction

		function void set_limit(logic [u2a_pkg::CNT_W-1:0] v);
			char_limit = v;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// accented latin-1 letters and the degree sign fold to plain ascii
		function logic [u2a_pkg::CHAR_W-1:0] fold_code_point(logic [u2a_pkg::CP_W-1:0] cp);
			case (cp)
				11'h0B0:                            return u2a_pkg::CH_STAR;
				11'h0C0, 11'h0C2:                   return 7'h41;
				11'h0C7:                            return 7'h43;
				11'h0C8, 11'h0C9, 11'h0CA:          return 7'h45;
				11'h0CE:                            return 7'h49;
				11'h0D4:                            return 7'h4F;
				11'h0D9, 11'h0DB:                   return 7'h55;
				11'h0E0, 11'h0E2, 11'h0E4:          return 7'h61;
				11'h0E7:                            return 7'h63;
				11'h0E8, 11'h0E9, 11'h0EA, 11'h0EB: return 7'h65;
				11'h0EC, 11'h0EE, 11'h0EF:          return 7'h69;
				11'h0F2, 11'h0F4, 11'h0F6:          return 7'h6F;
				11'h0F9, 11'h0FB, 11'h0FC:          return 7'h75;
				default:                            return u2a_pkg::CH_QUESTION;
			endcase
		endfunction

		// one character unless the string has used up its limit
		function void emit_char(logic [u2a_pkg::CHAR_W-1:0] ch);
			ascii_result_t r;
			if (at_limit || char_count >= char_limit) begin
				at_limit = 1;
				return;
			end
			r.ch   = ch;
			r.last = 1'b0;
			expected_q.push_back(r);
			char_count = char_count + 1'b1;
			if (char_count >= char_limit)
				at_limit = 1;
		endfunction

		// input transaction accepted
		function void note_byte(logic [u2a_pkg::BYTE_W-1:0] b);
			logic [u2a_pkg::CP_W-1:0] cp;
			ascii_result_t            r;
			bytes_seen++;
			if (b == 8'h00) begin
				r.ch   = u2a_pkg::CH_NUL;
				r.last = 1'b1;
				expected_q.push_back(r);
				clear_string();
				return;
			end
			if (at_limit)
				return;
			if (skip_left != 0) begin
				skip_left = skip_left - 1'b1;
				return;
			end
			if (want_second) begin
				// low six bits are taken even when not a continuation byte
				cp = {lead_bits, b[5:0]};
				want_second = 0;
				lead_bits   = '0;
				emit_char(fold_code_point(cp));
				return;
			end
			if (!b[7]) begin
				emit_char(b[u2a_pkg::CHAR_W-1:0]);
			end else if ((b & u2a_pkg::LEAD2_MASK) == u2a_pkg::LEAD2_PAT) begin
				lead_bits   = b[u2a_pkg::LEAD_W-1:0];
				want_second = 1;
			end else if ((b & u2a_pkg::LEAD3_MASK) == u2a_pkg::LEAD3_PAT) begin
				skip_left = u2a_pkg::SKIP_LEAD3;
				emit_char(u2a_pkg::CH_QUESTION);
			end else if ((b & u2a_pkg::LEAD4_MASK) == u2a_pkg::LEAD4_PAT) begin
				skip_left = u2a_pkg::SKIP_LEAD4;
				emit_char(u2a_pkg::CH_SPACE);
			end
		endfunction

		// output transaction accepted
		function void check_result(logic [7:0] data, logic last);
			ascii_result_t e;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected output: char %02h last %0d", data[6:0], last);
				return;
			end
			e = expected_q.pop_front();
			if (last)
				terms_seen++;
			else
				chars_seen++;
			if (data[u2a_pkg::CHAR_W-1:0] !== e.ch || last !== e.last) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("mismatch: expected char %02h last %0d, got char %02h last %0d",
						e.ch, e.last, data[6:0], last);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [11:0] cfg_wr_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;

	translit_scoreboard sb;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int idle_cycles    = 0;
	int limit_settings = 1;

	utf8_to_ascii_transliterator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),
		.m_axis_tlast  (m_tlast)
	);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// transaction monitor and receiver backpressure
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_byte(s_tdata);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata, m_tlast);
		end
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog expired with %0d results outstanding", sb.pending());
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	// present one byte and hold it until taken
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct && gap < 20)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// hold off the sender until every expected result is out
	task automatic drain_results();
		s_tvalid <= 1'b0;
		// let the monitor log the last accepted byte first
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [11:0] v);
		drain_results();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		sb.set_limit(v);
		cfg_wr_en <= 1'b0;
		limit_settings++;
	endtask

	function automatic logic [7:0] cont_byte();
		return 8'($urandom_range(8'hBF, 8'h80));
	endfunction

	// random text: mostly well-formed sequences, some noise and cut sequences
	task automatic send_random_text(input int n);
		int sent;
		int kind;
		sent = 0;
		while (sent < n) begin
			kind = $urandom_range(99);
			if (kind < 4) begin
				send_byte(8'h00);
				sent += 1;
			end else if (kind < 40) begin
				send_byte(8'($urandom_range(127, 1)));
				sent += 1;
			end else if (kind < 62) begin
				send_byte(8'hC3);
				send_byte(cont_byte());
				sent += 2;
			end else if (kind < 65) begin
				send_byte(8'hC2);
				send_byte(($urandom_range(1)) ? 8'hB0 : cont_byte());
				sent += 2;
			end else if (kind < 74) begin
				send_byte(8'($urandom_range(8'hDF, 8'hC0)));
				send_byte(($urandom_range(3) == 0) ? 8'($urandom_range(255, 1)) : cont_byte());
				sent += 2;
			end else if (kind < 82) begin
				send_byte(8'($urandom_range(8'hEF, 8'hE0)));
				send_byte(cont_byte());
				send_byte(($urandom_range(3) == 0) ? 8'($urandom_range(255, 1)) : cont_byte());
				sent += 3;
			end else if (kind < 89) begin
				send_byte(8'($urandom_range(8'hF7, 8'hF0)));
				send_byte(cont_byte());
				send_byte(cont_byte());
				send_byte(cont_byte());
				sent += 4;
			end else if (kind < 95) begin
				send_byte(8'($urandom_range(255)));
				sent += 1;
			end else begin
				// sequence cut short by an end of string
				case ($urandom_range(2))
					0: send_byte(8'($urandom_range(8'hDF, 8'hC0)));
					1: send_byte(8'($urandom_range(8'hEF, 8'hE0)));
					default: begin
						send_byte(8'($urandom_range(8'hF7, 8'hF0)));
						send_byte(cont_byte());
					end
				endcase
				send_byte(8'h00);
				sent += 3;
			end
		end
	endtask

	// random phase under one limit and one handshake pressure
	task automatic run_phase(input logic [11:0] lim, input int idle_pct, input int stall_pct);
		write_limit(lim);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		send_random_text(RUN_BYTES / 2);
		drain_results();
		send_random_text(RUN_BYTES - RUN_BYTES / 2);
	endtask

	// stimulus
	initial begin
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: ascii extremes and latin-1 folding under the reset limit
		send_byte(8'h01);
		send_byte(8'h7F);
		send_byte(8'hC3); send_byte(8'hA9);
		send_byte(8'hC2); send_byte(8'hB0);
		send_byte(8'hC3); send_byte(8'h80);
		send_byte(8'hDF); send_byte(8'hBF);
		// second byte that is not a continuation
		send_byte(8'hC3); send_byte(8'h41);
		// three- and four-byte leads with their skipped bytes
		send_byte(8'hE2); send_byte(8'h82); send_byte(8'hAC);
		send_byte(8'hF0); send_byte(8'h9F); send_byte(8'h98); send_byte(8'h80);
		// stray bytes
		send_byte(8'h80); send_byte(8'hF8); send_byte(8'hFF);
		send_byte(8'h00);
		// end of string in place of a second byte and of a skipped byte
		send_byte(8'hC3); send_byte(8'h00);
		send_byte(8'hF0); send_byte(8'h00);

		// smallest limit: one character, then drops until the terminator
		write_limit(12'd1);
		send_byte(8'h41); send_byte(8'h42); send_byte(8'h00);

		// limit lowered below the count of an open string
		write_limit(12'd4095);
		send_byte(8'h61); send_byte(8'h62);
		write_limit(12'd1);
		send_byte(8'h63); send_byte(8'h00);

		run_phase(12'd255, 0, 0);
		run_phase(12'd1, 51, 0);
		run_phase(12'd4095, 0, 51);
		run_phase(12'd3, 32, 32);
		run_phase(12'($urandom_range(40, 2)), 0, 0);
		run_phase(12'($urandom_range(4095, 1)), 51, 51);

		// wind down
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("run covered %0d input bytes, %0d characters and %0d terminators",
			sb.bytes_seen, sb.chars_seen, sb.terms_seen);
		$display("across %0d limit settings, %0d mismatches", limit_settings, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

`default_nettype wire
